// ===== rtl/ile_pkg.sv =====
`default_nettype none
package ile_pkg;

	localparam int VALUE_W = 32;
	localparam int INDEX_W = 6;
	localparam int OP_W    = 3;
	localparam int STAT_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_REMOVE = 3'd2,
		OP_SET    = 3'd3,
		OP_GET    = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE      = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic write;
		logic shift_up;
		logic shift_down;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/ile_cell.sv =====
`default_nettype none
module ile_cell import ile_pkg::*; #(
	parameter int PW  = 7,
	parameter int POS = 0
) (
	input  wire logic               clk,
	input  wire cell_ctrl_t         ctrl,
	input  wire logic [PW-1:0]      wr_pos,
	input  wire logic [PW-1:0]      idx,
	input  wire logic [VALUE_W-1:0] value,
	input  wire logic [VALUE_W-1:0] left,
	input  wire logic [VALUE_W-1:0] right,
	output logic      [VALUE_W-1:0] data,
	output logic      [VALUE_W-1:0] rd
);

	localparam logic [PW-1:0] POS_V = PW'(POS);

	logic [VALUE_W-1:0] data_q;

	// insert writes at idx and moves everything above it up by one;
	// remove pulls everything from idx upward down by one
	always_ff @(posedge clk) begin
		if (ctrl.write && (POS_V == wr_pos)) begin
			data_q <= value;
		end else if (ctrl.shift_up && (POS_V > idx)) begin
			data_q <= left;
		end else if (ctrl.shift_down && (POS_V >= idx)) begin
			data_q <= right;
		end
	end

	assign data = data_q;
	assign rd   = (POS_V == idx) ? data_q : '0;

endmodule
`default_nettype wire

// ===== rtl/ile_chain.sv =====
`default_nettype none
module ile_chain import ile_pkg::*; #(
	parameter int CAPACITY = 64,
	parameter int PW       = 7
) (
	input  wire logic               clk,
	input  wire cell_ctrl_t         ctrl,
	input  wire logic [PW-1:0]      wr_pos,
	input  wire logic [PW-1:0]      idx,
	input  wire logic [VALUE_W-1:0] value,
	output logic      [VALUE_W-1:0] rd_data
);

	logic [VALUE_W-1:0] data [CAPACITY];
	logic [VALUE_W-1:0] rd   [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_W-1:0] left_w;
		logic [VALUE_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = data[i-1];
		end

		if (i == CAPACITY-1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = data[i+1];
		end

		ile_cell #(
			.PW  (PW),
			.POS (i)
		) u_cell (
			.clk    (clk),
			.ctrl   (ctrl),
			.wr_pos (wr_pos),
			.idx    (idx),
			.value  (value),
			.left   (left_w),
			.right  (right_w),
			.data   (data[i]),
			.rd     (rd[i])
		);
	end

	// only the addressed cell drives nonzero
	always_comb begin
		rd_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_data = rd_data | rd[i];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/indexed_list_engine_unit.sv =====
// Indexed list engine: one word in, one word out.
// An accepted input word's result is loaded straight into the output register.
// Throughput: 1 word per cycle while in_stall is low; every cell of the chain shifts or loads in the
// same cycle, and get reads the addressed cell through an OR tree.
// Reset clears the count and the output valid; entry contents are not cleared.
`default_nettype none
module indexed_list_engine_unit import ile_pkg::*; #(
	parameter  int CAPACITY = 64,
	localparam int PW       = $clog2(CAPACITY + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [OP_W-1:0]    operation,
	input  wire logic [INDEX_W-1:0] index,
	input  wire logic [VALUE_W-1:0] value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic      [VALUE_W-1:0] read_value,
	output logic      [STAT_W-1:0]  status,
	output logic      [PW-1:0]      element_count
);

	localparam int LW = (PW > INDEX_W) ? PW : INDEX_W;
	localparam logic [PW-1:0] CAP_V = PW'(CAPACITY);

	logic [PW-1:0]      count_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] read_value_q;
	status_t            status_q;
	logic [PW-1:0]      count_out_q;

	logic               accept;
	logic               in_range;
	logic               full;
	logic [PW-1:0]      idx_p;
	cell_ctrl_t         ctrl;
	cell_ctrl_t         ctrl_g;
	logic [PW-1:0]      wr_pos;
	logic               rd_sel;
	status_t            st_d;
	logic [PW-1:0]      count_d;
	logic [VALUE_W-1:0] chain_rd;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	// range check at full width; idx_p may alias only when the check fails
	assign in_range = LW'(index) < LW'(count_q);
	assign full     = (count_q == CAP_V);
	assign idx_p    = PW'(index);

	always_comb begin
		ctrl    = '0;
		wr_pos  = idx_p;
		rd_sel  = 1'b0;
		st_d    = ST_DONE;
		count_d = count_q;
		case (op_t'(operation))
			OP_APPEND: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					ctrl.write = 1'b1;
					wr_pos     = count_q;
					count_d    = count_q + PW'(1);
				end
			end
			OP_INSERT: begin
				if (!in_range) begin
					st_d = ST_BAD_INDEX;
				end else if (full) begin
					st_d = ST_FULL;
				end else begin
					ctrl.write    = 1'b1;
					ctrl.shift_up = 1'b1;
					count_d       = count_q + PW'(1);
				end
			end
			OP_REMOVE: begin
				if (!in_range) begin
					st_d = ST_BAD_INDEX;
				end else begin
					ctrl.shift_down = 1'b1;
					count_d         = count_q - PW'(1);
				end
			end
			OP_SET: begin
				if (!in_range) begin
					st_d = ST_BAD_INDEX;
				end else begin
					ctrl.write = 1'b1;
				end
			end
			OP_GET: begin
				if (!in_range) begin
					st_d = ST_BAD_INDEX;
				end else begin
					rd_sel = 1'b1;
				end
			end
			default: begin
				// unknown codes leave the list alone
			end
		endcase
	end

	assign ctrl_g = accept ? ctrl : '0;

	ile_chain #(
		.CAPACITY (CAPACITY),
		.PW       (PW)
	) u_chain (
		.clk     (clk),
		.ctrl    (ctrl_g),
		.wr_pos  (wr_pos),
		.idx     (idx_p),
		.value   (value),
		.rd_data (chain_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= rd_sel ? chain_rd : '0;
			status_q     <= st_d;
			count_out_q  <= count_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_value    = read_value_q;
	assign status        = status_q;
	assign element_count = count_out_q;

endmodule
`default_nettype wire
